// ===== hdl/sv2x2_pkg.sv =====
// Shared constants, types and per-step functions for the 2x2 singular value pipeline.
package sv2x2_pkg;

  localparam int unsigned InW    = 32;
  localparam int unsigned OutW   = 34;
  localparam int unsigned Guard  = 8;
  localparam int unsigned SqW    = 65;                   // bits of s^2 + g^2
  localparam int unsigned RadW   = SqW + 2 * Guard + 1;  // even radicand width
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 3;
  localparam int unsigned NumW   = 65;                   // mn*mx plus half divisor
  localparam int unsigned DRemW  = OutW + 1;

  typedef struct packed {
    logic [2*InW-1:0] mnmx;
    logic [InW-1:0]   ga;
    logic             zd;   // a diagonal entry is zero
    logic             uf;   // ratio mx/ga rounds to zero
  } side_t;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [NumW-1:0]  num;
    logic [DRemW-1:0] rem;
    logic [OutW-1:0]  quo;
  } div_t;

  // One result bit of a restoring square root.
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t           r;
    logic [RemW-1:0] sh;
    logic [RemW-1:0] trial;
    sh    = {s.rem[RemW-3:0], s.rad[RadW-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[RadW-3:0], 2'b00};
    if (sh >= trial) begin
      r.rem  = sh - trial;
      r.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = sh;
      r.root = {s.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of a restoring division.
  function automatic div_t div_step(div_t s, logic [OutW-1:0] d);
    div_t             r;
    logic [DRemW-1:0] sh;
    sh    = {s.rem[DRemW-2:0], s.num[NumW-1]};
    r.num = {s.num[NumW-2:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      r.rem = sh - {1'b0, d};
      r.quo = {s.quo[OutW-2:0], 1'b1};
    end else begin
      r.rem = sh;
      r.quo = {s.quo[OutW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== hdl/singular_values_2x2_upper.sv =====
// Singular values of an upper-triangular 2x2 matrix [f g; 0 h], fully pipelined.
// Takes one matrix per clock cycle and returns one result per matrix. The pipeline
// runs through the magnitude, square and radicand setup registers, a stage for each
// bit of the two guarded square roots (41 stages), a register that forms sigma_max
// and the divide operands, a stage for each quotient bit of the determinant divide
// (34 stages), and the output register.
// The whole pipeline holds when a result waits at the output and the sink is not
// ready; saturated is always 0 for 32-bit inputs.
module singular_values_2x2_upper import sv2x2_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // entry_f[31:0], entry_g[63:32], entry_h[95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // sigma_min[33:0], sigma_max[67:34], saturated[68]
);

  localparam int unsigned NSq  = RootW;
  localparam int unsigned NDiv = OutW;
  localparam int unsigned CmpW = InW + FRAC_BITS;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  function automatic logic [InW-1:0] mag(logic [InW-1:0] v);
    return v[InW-1] ? (~v + 1'b1) : v;
  endfunction

  // Stage 1: magnitudes and branch flags
  logic [InW-1:0] fa, ga, ha;
  logic           v1_q;
  logic [InW-1:0] mn1_q, mx1_q, ga1_q;
  logic           zd1_q, uf1_q;
  assign fa = mag(s_axis_tdata[31:0]);
  assign ga = mag(s_axis_tdata[63:32]);
  assign ha = mag(s_axis_tdata[95:64]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mn1_q <= (fa < ha) ? fa : ha;
      mx1_q <= (fa < ha) ? ha : fa;
      ga1_q <= ga;
      zd1_q <= (fa == '0) || (ha == '0);
      uf1_q <= ({((fa < ha) ? ha : fa), {FRAC_BITS{1'b0}}} < CmpW'(ga));
    end
  end

  // Stage 2: squares and determinant
  logic               v2_q;
  logic [2*InW+1:0]   s2_q;
  logic [2*InW-1:0]   d2_q, g2_q;
  side_t              sd2_q;
  logic [InW:0]       sum1;
  logic [InW-1:0]     dif1;
  assign sum1 = {1'b0, mx1_q} + {1'b0, mn1_q};
  assign dif1 = mx1_q - mn1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q       <= sum1 * sum1;
      d2_q       <= dif1 * dif1;
      g2_q       <= ga1_q * ga1_q;
      sd2_q.mnmx <= mn1_q * mx1_q;
      sd2_q.ga   <= ga1_q;
      sd2_q.zd   <= zd1_q;
      sd2_q.uf   <= uf1_q;
    end
  end

  // Stage 3: guarded radicands, then the bit-serial root pipelines
  logic  vs_q [NSq+1];
  side_t ss_q [NSq+1];
  sqrt_t ps_q [NSq+1];
  sqrt_t qs_q [NSq+1];
  logic [SqW-1:0] psum, qsum;
  assign psum = SqW'(s2_q) + SqW'(g2_q);
  assign qsum = SqW'(d2_q) + SqW'(g2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else if (en) begin
      vs_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss_q[0]      <= sd2_q;
      ps_q[0].rad  <= {1'b0, psum, {2*Guard{1'b0}}};
      ps_q[0].rem  <= '0;
      ps_q[0].root <= '0;
      qs_q[0].rad  <= {1'b0, qsum, {2*Guard{1'b0}}};
      qs_q[0].rem  <= '0;
      qs_q[0].root <= '0;
    end
  end

  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else if (en) begin
        vs_q[k+1] <= vs_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ss_q[k+1] <= ss_q[k];
        ps_q[k+1] <= sqrt_step(ps_q[k]);
        qs_q[k+1] <= sqrt_step(qs_q[k]);
      end
    end
  end

  // Form sigma_max and the divide operands
  logic [RootW:0]  rsum;
  logic [OutW-1:0] smax_c;
  logic [OutW-1:0] smax_g;
  logic [InW-1:0]  gs;
  assign gs     = ss_q[NSq].ga;
  assign rsum   = RootW'(ps_q[NSq].root) + RootW'(qs_q[NSq].root) + (RootW+1)'(1 << Guard);
  assign smax_g = (rsum[RootW:Guard+1] == '0) ? OutW'(1) : OutW'(rsum[RootW:Guard+1]);

  always_comb begin
    priority if (ss_q[NSq].zd) begin
      smax_c = OutW'((ps_q[NSq].root + RootW'(1 << (Guard - 1))) >> Guard);
    end else if (ss_q[NSq].uf) begin
      smax_c = OutW'(gs);
    end else begin
      smax_c = smax_g;
    end
  end

  logic            vd_q  [NDiv+1];
  logic            zdd_q [NDiv+1];
  logic [OutW-1:0] dv_q  [NDiv+1];
  logic [OutW-1:0] mxd_q [NDiv+1];
  div_t            dd_q  [NDiv+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q[0] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= vs_q[NSq];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zdd_q[0]    <= ss_q[NSq].zd;
      dv_q[0]     <= smax_c;
      mxd_q[0]    <= smax_c;
      dd_q[0].num <= NumW'(ss_q[NSq].mnmx) + NumW'(smax_c >> 1);
      dd_q[0].rem <= '0;
      dd_q[0].quo <= '0;
    end
  end

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[k+1] <= 1'b0;
      end else if (en) begin
        vd_q[k+1] <= vd_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        zdd_q[k+1] <= zdd_q[k];
        dv_q[k+1]  <= dv_q[k];
        mxd_q[k+1] <= mxd_q[k];
        dd_q[k+1]  <= (k == 0) ? div_step(div_t'({dd_q[k].num << (NumW - OutW),
                                  DRemW'(dd_q[k].num >> OutW), dd_q[k].quo}), dv_q[k])
                               : div_step(dd_q[k], dv_q[k]);
      end
    end
  end

  // Output register
  logic [OutW-1:0] smin_q, smaxo_q;
  logic            vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vd_q[NDiv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      smin_q  <= zdd_q[NDiv] ? '0 : dd_q[NDiv].quo;
      smaxo_q <= mxd_q[NDiv];
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {3'b000, 1'b0, smaxo_q, smin_q};

endmodule
